// ===== hdl/spq_pkg.sv =====
// Shared types and codes for the stable sorted priority queue.
// Used by spq_cell and by the stable_priority_queue_unit top level.
package spq_pkg;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // Status codes returned with every result item.
    typedef enum logic [2:0] {
        STAT_OK       = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_FULL     = 3'd2,
        STAT_NOTFOUND = 3'd3,
        STAT_DUP      = 3'd4
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY,
        S_REPORT,
        S_OUT
    } state_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic eval;   // compare the held entry against the item
        logic insert; // open a gap and place the new entry
        logic shift;  // close a gap by pulling from the right neighbour
        logic pop;    // every cell pulls from the right (head leaves)
    } cell_ctl_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds a tag, a priority and a valid bit.
// Depends on spq_pkg for the broadcast control struct.
module spq_cell
    import spq_pkg::*;
#(
    parameter int TAG_WIDTH  = 8,
    parameter int PRIO_WIDTH = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctl_t             ctl,
    input  logic [TAG_WIDTH-1:0]  new_tag,
    input  logic [PRIO_WIDTH-1:0] new_prio,
    input  logic                  left_valid,
    input  logic [TAG_WIDTH-1:0]  left_tag,
    input  logic [PRIO_WIDTH-1:0] left_prio,
    input  logic                  left_gt,
    input  logic                  right_valid,
    input  logic [TAG_WIDTH-1:0]  right_tag,
    input  logic [PRIO_WIDTH-1:0] right_prio,
    input  logic                  prefix_in,
    output logic                  valid,
    output logic [TAG_WIDTH-1:0]  tag,
    output logic [PRIO_WIDTH-1:0] prio,
    output logic                  gt,
    output logic                  prefix_out
);

    logic                  valid_reg, valid_next;
    logic [TAG_WIDTH-1:0]  tag_reg, tag_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic                  gt_reg, gt_next;
    logic                  match_reg, match_next;
    logic                  shift_here;

    // A match here or in any cell to the left means this slot closes up.
    assign prefix_out = prefix_in | match_reg;
    assign shift_here = ctl.pop | prefix_out;

    // Next contents of the slot.
    always_comb
    begin
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        gt_next    = gt_reg;
        match_next = match_reg;
        if (ctl.eval)
        begin
            // An empty slot counts as holding a larger priority.
            gt_next    = !valid_reg || (prio_reg > new_prio);
            match_next = valid_reg && (tag_reg == new_tag);
        end
        if (ctl.insert && gt_reg)
        begin
            if (left_gt)
            begin
                valid_next = left_valid;
                tag_next   = left_tag;
                prio_next  = left_prio;
            end
            else
            begin
                valid_next = 1'b1;
                tag_next   = new_tag;
                prio_next  = new_prio;
            end
        end
        else if (ctl.shift && shift_here)
        begin
            valid_next = right_valid;
            tag_next   = right_tag;
            prio_next  = right_prio;
        end
    end

    // Control bits of the slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            gt_reg    <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            gt_reg    <= gt_next;
            match_reg <= match_next;
        end
    end

    // Payload of the slot.
    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign prio  = prio_reg;
    assign gt    = gt_reg;

endmodule

// ===== hdl/stable_priority_queue_unit.sv =====
// Stable sorted priority queue: a chain of DEPTH cells kept in priority order.
// Each item is taken in the idle state and runs through the compare, update and report
// steps in turn over the chain before its result is shown; no new item is taken until
// that result has been accepted on the result side.
// Reset empties the queue at once by clearing every cell's valid bit.
module stable_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int TAG_WIDTH  = 8,
    parameter int PRIO_WIDTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [TAG_WIDTH-1:0]          tag,
    input  logic [PRIO_WIDTH-1:0]         prio,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [TAG_WIDTH-1:0]          out_tag,
    output logic [PRIO_WIDTH-1:0]         out_prio,
    output logic [TAG_WIDTH-1:0]          head_tag,
    output logic [TAG_WIDTH-1:0]          tail_tag,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg;
    logic [TAG_WIDTH-1:0]  tag_reg;
    logic [PRIO_WIDTH-1:0] prio_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    status_t               status_reg, status_next;
    logic [TAG_WIDTH-1:0]  otag_reg, otag_next;
    logic [PRIO_WIDTH-1:0] oprio_reg, oprio_next;
    logic [TAG_WIDTH-1:0]  head_reg, head_next;
    logic [TAG_WIDTH-1:0]  tail_reg, tail_next;
    cell_ctl_t             ctl;

    logic [DEPTH-1:0]      cell_valid;
    logic [DEPTH-1:0]      cell_gt;
    logic [DEPTH-1:0]      cell_prefix;
    logic [DEPTH-1:0]      cell_is_tail;
    logic [TAG_WIDTH-1:0]  cell_tag  [DEPTH];
    logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
    logic                  any_match;
    logic                  full;
    logic [TAG_WIDTH-1:0]  tail_or;

    // The chain of cells, each wired to its two neighbours.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                  l_valid, l_gt, r_valid, p_in;
        logic [TAG_WIDTH-1:0]  l_tag, r_tag;
        logic [PRIO_WIDTH-1:0] l_prio, r_prio;

        if (i == 0)
        begin : g_first
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
            assign l_tag   = '0;
            assign l_prio  = '0;
            assign p_in    = 1'b0;
        end
        else
        begin : g_inner_left
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
            assign l_tag   = cell_tag[i-1];
            assign l_prio  = cell_prio[i-1];
            assign p_in    = cell_prefix[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_tag   = '0;
            assign r_prio  = '0;
        end
        else
        begin : g_inner_right
            assign r_valid = cell_valid[i+1];
            assign r_tag   = cell_tag[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        // The last held entry is the tail.
        assign cell_is_tail[i] = cell_valid[i] && !r_valid;

        spq_cell #(
            .TAG_WIDTH  (TAG_WIDTH),
            .PRIO_WIDTH (PRIO_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_tag     (tag_reg),
            .new_prio    (prio_reg),
            .left_valid  (l_valid),
            .left_tag    (l_tag),
            .left_prio   (l_prio),
            .left_gt     (l_gt),
            .right_valid (r_valid),
            .right_tag   (r_tag),
            .right_prio  (r_prio),
            .prefix_in   (p_in),
            .valid       (cell_valid[i]),
            .tag         (cell_tag[i]),
            .prio        (cell_prio[i]),
            .gt          (cell_gt[i]),
            .prefix_out  (cell_prefix[i])
        );
    end

    assign any_match = cell_prefix[DEPTH-1];
    assign full      = (count_reg == CNT_W'(DEPTH));

    // Exactly one cell is the tail when the queue holds anything.
    always_comb
    begin
        tail_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_is_tail[i])
            begin
                tail_or = tail_or | cell_tag[i];
            end
        end
    end

    // Sequencer: compare, update, report, then hold the result.
    always_comb
    begin
        state_next  = state_reg;
        ctl         = '0;
        count_next  = count_reg;
        status_next = status_reg;
        otag_next   = otag_reg;
        oprio_next  = oprio_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ctl.eval   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                status_next = STAT_OK;
                otag_next   = '0;
                oprio_next  = '0;
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (any_match)
                        begin
                            status_next = STAT_DUP;
                        end
                        else
                        begin
                            ctl.insert = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            ctl.shift  = 1'b1;
                            ctl.pop    = 1'b1;
                            otag_next  = cell_tag[0];
                            oprio_next = cell_prio[0];
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (!any_match)
                        begin
                            status_next = STAT_NOTFOUND;
                        end
                        else
                        begin
                            ctl.shift  = 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    CMD_NONE:
                    begin
                        status_next = STAT_OK;
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                head_next  = cell_valid[0] ? cell_tag[0] : '0;
                tail_next  = tail_or;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Captured item and result payload.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            cmd_reg  <= cmd_t'(cmd);
            tag_reg  <= tag;
            prio_reg <= prio;
        end
        status_reg <= status_next;
        otag_reg   <= otag_next;
        oprio_reg  <= oprio_next;
        head_reg   <= head_next;
        tail_reg   <= tail_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign out_tag   = otag_reg;
    assign out_prio  = oprio_reg;
    assign head_tag  = head_reg;
    assign tail_tag  = tail_reg;
    assign count     = count_reg;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // In the idle state the number of held entries always matches the count.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> $countones(cell_valid) == 32'(count_reg))
        else $error("cell valid bits disagree with the count");

    // A successful insert grows the queue by exactly one entry.
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.insert |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not add one entry");

    // A new item is never taken while a result is still on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the stable sorted priority queue top level.
// Depends on spq_pkg for the command and status codes; drives the valid/stall
// channels and checks every result item against a behavioural queue model.
`timescale 1ns / 1ps

module tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;

    // One result item as the block should report it.
    typedef struct {
        status_t    status;
        logic [7:0] out_tag;
        logic [7:0] out_prio;
        logic [7:0] head_tag;
        logic [7:0] tail_tag;
        logic [4:0] count;
    } queue_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] cmd;
    logic [7:0] tag;
    logic [7:0] prio;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [7:0] out_tag;
    logic [7:0] out_prio;
    logic [7:0] head_tag;
    logic [7:0] tail_tag;
    logic [4:0] count;

    // Model of the queue contents, kept in service order.
    logic [7:0]    held_tag  [QUEUE_DEPTH];
    logic [7:0]    held_prio [QUEUE_DEPTH];
    int            held_count;
    queue_result_t expected_results[$];

    int fail_count;
    int send_idle_max;
    int recv_idle_max;
    int hold_request;

    stable_priority_queue_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .tag       (tag),
        .prio      (prio),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .out_tag   (out_tag),
        .out_prio  (out_prio),
        .head_tag  (head_tag),
        .tail_tag  (tail_tag),
        .count     (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Returns the slot holding the given tag, or -1 when it is absent.
    function automatic int held_slot(logic [7:0] t);
        for (int i = 0; i < held_count; i++)
        begin
            if (held_tag[i] == t)
                return i;
        end
        return -1;
    endfunction

    // Closes the gap left at slot s by moving later entries forward.
    function automatic void drop_entry(int s);
        for (int i = s; i + 1 < held_count; i++)
        begin
            held_tag[i]  = held_tag[i + 1];
            held_prio[i] = held_prio[i + 1];
        end
        held_count--;
    endfunction

    // Applies one command to the model and returns the result it causes.
    function automatic queue_result_t apply_command(cmd_t c, logic [7:0] t, logic [7:0] p);
        queue_result_t r;
        int            pos;
        r.status   = STAT_OK;
        r.out_tag  = '0;
        r.out_prio = '0;
        r.head_tag = '0;
        r.tail_tag = '0;
        case (c)
            CMD_INSERT:
            begin
                if (held_count >= QUEUE_DEPTH)
                    r.status = STAT_FULL;
                else if (held_slot(t) >= 0)
                    r.status = STAT_DUP;
                else
                begin
                    // An equal priority goes behind those already held.
                    pos = held_count;
                    while (pos > 0 && p < held_prio[pos - 1])
                        pos--;
                    for (int i = held_count; i > pos; i--)
                    begin
                        held_tag[i]  = held_tag[i - 1];
                        held_prio[i] = held_prio[i - 1];
                    end
                    held_tag[pos]  = t;
                    held_prio[pos] = p;
                    held_count++;
                end
            end
            CMD_POP:
            begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.out_tag  = held_tag[0];
                    r.out_prio = held_prio[0];
                    drop_entry(0);
                end
            end
            CMD_REMOVE:
            begin
                pos = held_slot(t);
                if (pos < 0)
                    r.status = STAT_NOTFOUND;
                else
                    drop_entry(pos);
            end
            default:
            begin
            end
        endcase
        if (held_count > 0)
        begin
            r.head_tag = held_tag[0];
            r.tail_tag = held_tag[held_count - 1];
        end
        r.count = 5'(held_count);
        return r;
    endfunction

    // Counts a failure and reports only the first few in detail.
    task automatic log_failure(string msg);
        if (fail_count < MAX_REPORTS)
            $display("ERROR: %s", msg);
        fail_count++;
    endtask

    // Offers one item after a random gap and records its expected result
    // once the block has taken it.
    task automatic send_item(cmd_t c, logic [7:0] t, logic [7:0] p);
        int gap;
        gap = $urandom_range(0, send_idle_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        tag      <= t;
        prio     <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(apply_command(c, t, p));
    endtask

    // Draws one command that suits the current fill level: mostly inserts
    // while filling, mostly pops and removes while draining.
    task automatic random_item(bit filling);
        int         roll;
        int         ins_pct;
        int         pop_pct;
        logic [7:0] t;
        logic [7:0] p;
        roll    = $urandom_range(0, 99);
        ins_pct = filling ? 60 : 25;
        pop_pct = filling ? 25 : 50;
        t       = 8'($urandom_range(0, 255));
        p       = 8'($urandom_range(0, 255));
        if (roll < ins_pct)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15 && held_count > 0)
                t = held_tag[$urandom_range(0, held_count - 1)];
            else if (roll < 65)
                t = 8'($urandom_range(0, 31));
            roll = $urandom_range(0, 99);
            if (roll < 50)
                p = 8'($urandom_range(0, 7));
            else if (roll < 60)
                p = roll[0] ? 8'hFF : 8'h00;
            send_item(CMD_INSERT, t, p);
        end
        else if (roll < ins_pct + pop_pct)
            send_item(CMD_POP, t, p);
        else if (roll < 97)
        begin
            if ($urandom_range(0, 99) < 70 && held_count > 0)
                t = held_tag[$urandom_range(0, held_count - 1)];
            send_item(CMD_REMOVE, t, p);
        end
        else
            send_item(CMD_NONE, t, p);
    endtask

    // Commands on an empty queue.
    task automatic test_empty_queue();
        send_item(CMD_POP, 8'h00, 8'h00);
        send_item(CMD_REMOVE, 8'hFF, 8'h00);
        send_item(CMD_NONE, 8'hFF, 8'hFF);
    endtask

    // Priority order, first-in first-out among ties, and the field extremes.
    task automatic test_ordering();
        send_item(CMD_INSERT, 8'h00, 8'hFF);
        send_item(CMD_INSERT, 8'hFF, 8'h00);
        send_item(CMD_INSERT, 8'd7, 8'd128);
        send_item(CMD_INSERT, 8'd9, 8'd128);
        send_item(CMD_INSERT, 8'd11, 8'd128);
        send_item(CMD_POP, 8'h00, 8'h00);
    endtask

    // Duplicate insert, removal from the middle and removal of an absent tag.
    task automatic test_rejected_and_removed();
        send_item(CMD_INSERT, 8'd9, 8'd3);
        send_item(CMD_REMOVE, 8'd9, 8'h00);
        send_item(CMD_REMOVE, 8'd42, 8'h00);
    endtask

    // Fill to capacity, then insert both a held tag and a new one.
    task automatic test_fill_to_full();
        while (held_count < QUEUE_DEPTH)
            send_item(CMD_INSERT, 8'(100 + held_count), 8'($urandom_range(0, 255)));
        send_item(CMD_INSERT, 8'h00, 8'd1);
        send_item(CMD_INSERT, 8'd200, 8'd1);
    endtask

    // Random traffic wandering between empty and full, with idling that
    // changes from block to block.
    task automatic test_random_traffic(int n);
        bit filling;
        int phase_left;
        filling    = 1'b0;
        phase_left = 0;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 0)
            begin
                send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
                recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 14;
            end
            if (phase_left == 0)
            begin
                filling    = ~filling;
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            random_item(filling);
        end
    endtask

    // Back-to-back traffic with neither side idling.
    task automatic test_full_rate(int n);
        send_idle_max = 0;
        recv_idle_max = 0;
        for (int i = 0; i < n; i++)
            random_item(i % 40 < 20);
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the block keeps its result on offer and stalls its input.
    task automatic test_output_hold(int n);
        send_idle_max = 0;
        recv_idle_max = 0;
        hold_request  = HOLD_CYCLES;
        for (int i = 0; i < n; i++)
            random_item(1'b1);
        send_idle_max = 14;
        recv_idle_max = 14;
    endtask

    // Result receiver: random stall before each item, plus any long hold-off.
    initial
    begin : result_receiver
        int stall_for;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall_for    = $urandom_range(0, recv_idle_max) + hold_request;
            hold_request = 0;
            if (stall_for > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_for) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin : check_result
        queue_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                log_failure($sformatf("result with nothing expected: status %0d tag %0d",
                                      status, out_tag));
            else
            begin
                e = expected_results.pop_front();
                if (status !== e.status || out_tag !== e.out_tag ||
                    out_prio !== e.out_prio || head_tag !== e.head_tag ||
                    tail_tag !== e.tail_tag || count !== e.count)
                    log_failure($sformatf({"mismatch: expected st %0d tag %0d prio %0d ",
                        "head %0d tail %0d cnt %0d, got st %0d tag %0d prio %0d ",
                        "head %0d tail %0d cnt %0d"},
                        e.status, e.out_tag, e.out_prio, e.head_tag, e.tail_tag,
                        e.count, status, out_tag, out_prio, head_tag, tail_tag, count));
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Reset, run the tests in turn, then drain and report.
    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        cmd           <= CMD_NONE;
        tag           <= '0;
        prio          <= '0;
        out_stall     <= 1'b0;
        held_count    = 0;
        fail_count    = 0;
        send_idle_max = 14;
        recv_idle_max = 14;
        hold_request  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_ordering();
        test_rejected_and_removed();
        test_fill_to_full();
        test_random_traffic(850);
        test_full_rate(150);
        test_output_hold(40);
        test_random_traffic(100);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== stable_priority_queue_unit.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/stable_priority_queue_unit.sv
verif/tb.sv
